@@ rtl/lcp_pkg.sv @@
// Package for the 3D line closest-points pipeline: widths shared by the top level and
// the divider lane, stage numbering, register codes and the top level's product table.
// Depends on nothing.
`default_nettype none

package lcp_pkg;

	// Coordinate format
	localparam int CW     = 32;
	localparam int FRAC   = 16;
	localparam int PW     = CW + 1;
	localparam int TW     = 2 * PW;
	localparam int DW     = TW + 2;

	// Multiplier digit and operand widths
	localparam int DG     = 23;
	localparam int ND1    = 3;
	localparam int MW1    = ND1 * DG;
	localparam int PMW    = 2 * MW1;
	localparam int SW     = PMW + 2;
	localparam int ND2    = 6;
	localparam int MW2    = ND2 * DG;
	localparam int NW     = MW2 + PW;
	localparam int NPAIR  = ND2 / 2;

	// Divider and stage numbering
	localparam int QB     = 34;
	localparam int DV_ST  = QB + 2;
	localparam int ST_DIV = 14;
	localparam int NS     = ST_DIV + DV_ST;
	localparam int NLANE  = 6;

	// Configuration port
	localparam int AW     = 3;
	localparam int PDW    = 32;
	localparam int ECW    = 16;
	localparam int EDW    = 32;
	localparam int EPS_SH = 3 * FRAC;
	localparam logic [ECW-1:0] EPS_COORD_RST = ECW'(7);
	localparam logic [EDW-1:0] EPS_DENOM_RST = EDW'(7);

	typedef enum logic {
		REG_EPS_COORD = 1'b0,
		REG_EPS_DENOM = 1'b1
	} reg_idx_t;

	// Dot product slots
	localparam int D1343 = 0;
	localparam int D4321 = 1;
	localparam int D1321 = 2;
	localparam int D4343 = 3;
	localparam int D2121 = 4;
	localparam int NDOT  = 5;

	// Pairs of dot products that are multiplied: the denominator terms first,
	// then the numerator for line A, then the numerator for line B.
	localparam int NPROD = 6;
	localparam int PA [NPROD] = '{D2121, D4321, D1343, D1321, D1343, D1321};
	localparam int PB [NPROD] = '{D4343, D4321, D4321, D4343, D2121, D4321};

	typedef struct packed {
		logic num_neg;
		logic den_neg;
	} sgn_t;

endpackage

`default_nettype wire

@@ rtl/lcp_div.sv @@
// One divider lane: a restoring divider of one quotient bit per stage, followed by
// the offset add and saturation to a coordinate. Depends on lcp_pkg.
`default_nettype none

module lcp_div (
	input  logic                             clk,
	input  logic [lcp_pkg::DV_ST-1:0]        en,
	input  lcp_pkg::sgn_t                    sgn,
	input  logic [lcp_pkg::NW-1:0]           nm,
	input  logic [lcp_pkg::MW2-1:0]          dm,
	input  logic signed [lcp_pkg::CW-1:0]    base,
	output logic signed [lcp_pkg::CW-1:0]    res
);
	import lcp_pkg::*;

	localparam int TRW = MW2 + QB;
	localparam int RSW = QB + 2;
	localparam logic signed [RSW-1:0] HI = {{(RSW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [RSW-1:0] LO = ~HI;

	logic [NW-1:0]          rem_s  [QB+1];
	logic [QB-1:0]          q_s    [QB+1];
	logic [MW2-1:0]         dm_s   [QB+1];
	logic                   ovf_s  [QB+1];
	logic                   neg_s  [QB+1];
	logic signed [CW-1:0]   base_s [QB+1];
	logic [QB-1:0]          qm;
	logic signed [RSW-1:0]  qv;
	logic signed [RSW-1:0]  sum;

	// Entry stage flags a quotient too large for any coordinate; each later stage
	// settles one quotient bit, most significant first.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= nm;
			dm_s[0]   <= dm;
			q_s[0]    <= '0;
			ovf_s[0]  <= TRW'(nm) >= (TRW'(dm) << QB);
			neg_s[0]  <= sgn.num_neg ^ sgn.den_neg;
			base_s[0] <= base;
		end
		for (int k = 1; k <= QB; k++) begin
			if (en[k]) begin
				if (TRW'(rem_s[k-1]) >= (TRW'(dm_s[k-1]) << (QB - k))) begin
					rem_s[k] <= NW'(TRW'(rem_s[k-1]) - (TRW'(dm_s[k-1]) << (QB - k)));
					q_s[k]   <= q_s[k-1] | (QB'(1) << (QB - k));
				end else begin
					rem_s[k] <= rem_s[k-1];
					q_s[k]   <= q_s[k-1];
				end
				dm_s[k]   <= dm_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				base_s[k] <= base_s[k-1];
			end
		end
		if (en[QB+1]) begin
			res <= (sum > HI) ? HI[CW-1:0] : ((sum < LO) ? LO[CW-1:0] : sum[CW-1:0]);
		end
	end

	// An overflowing quotient is pinned at full scale, which always saturates.
	always_comb begin
		qm  = ovf_s[QB] ? '1 : q_s[QB];
		qv  = neg_s[QB] ? -RSW'(qm) : RSW'(qm);
		sum = RSW'(base_s[QB]) + qv;
	end

endmodule

`default_nettype wire

@@ rtl/line_closest_points_3d.sv @@
// Top level of the 3D line closest-points pipeline: differences, dot products,
// wide products in digits, six divider lanes and the result register.
// Depends on lcp_pkg and lcp_div.
//
//   channel   handshake               payload
//   request   req_valid / req_stall   a_start_*, a_end_*, b_start_*, b_end_*
//   result    res_valid / res_stall   found, closest_a_*, closest_b_*
//   config    APB psel/penable        eps_coord at 0x0, eps_denom at 0x4
//
// The pipeline has 50 register stages; one request is taken per cycle
// while req_stall is low.
// The 34 quotient stages of the divider lanes set most of the depth.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and a request is taken while a result waits in the output register.
// Reset clears the valid bits and loads both thresholds with 7.
`default_nettype none

module line_closest_points_3d (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic signed [lcp_pkg::CW-1:0]  a_start_x,
	input  logic signed [lcp_pkg::CW-1:0]  a_start_y,
	input  logic signed [lcp_pkg::CW-1:0]  a_start_z,
	input  logic signed [lcp_pkg::CW-1:0]  a_end_x,
	input  logic signed [lcp_pkg::CW-1:0]  a_end_y,
	input  logic signed [lcp_pkg::CW-1:0]  a_end_z,
	input  logic signed [lcp_pkg::CW-1:0]  b_start_x,
	input  logic signed [lcp_pkg::CW-1:0]  b_start_y,
	input  logic signed [lcp_pkg::CW-1:0]  b_start_z,
	input  logic signed [lcp_pkg::CW-1:0]  b_end_x,
	input  logic signed [lcp_pkg::CW-1:0]  b_end_y,
	input  logic signed [lcp_pkg::CW-1:0]  b_end_z,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic                           found,
	output logic signed [lcp_pkg::CW-1:0]  closest_a_x,
	output logic signed [lcp_pkg::CW-1:0]  closest_a_y,
	output logic signed [lcp_pkg::CW-1:0]  closest_a_z,
	output logic signed [lcp_pkg::CW-1:0]  closest_b_x,
	output logic signed [lcp_pkg::CW-1:0]  closest_b_y,
	output logic signed [lcp_pkg::CW-1:0]  closest_b_z,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lcp_pkg::AW-1:0]         paddr,
	input  logic [lcp_pkg::PDW-1:0]        pwdata,
	output logic [lcp_pkg::PDW-1:0]        prdata,
	output logic                           pready
);
	import lcp_pkg::*;

	// Handshake and configuration
	logic [NS:1]            en;
	logic [NS:1]            vld_q;
	logic [ECW-1:0]         eps_coord_q;
	logic [EDW-1:0]         eps_denom_q;
	reg_idx_t               ridx;

	// Input points as vectors
	logic signed [CW-1:0]   as_c [3];
	logic signed [CW-1:0]   ae_c [3];
	logic signed [CW-1:0]   bs_c [3];
	logic signed [CW-1:0]   be_c [3];

	// Vectors carried down to the divider lanes
	logic signed [CW-1:0]   p1_s  [ST_DIV-1:1][3];
	logic signed [CW-1:0]   p3_s  [ST_DIV-1:1][3];
	logic signed [PW-1:0]   p21_s [ST_DIV-1:1][3];
	logic signed [PW-1:0]   p43_s [ST_DIV-1:1][3];
	logic signed [PW-1:0]   p13_s1 [3];
	logic                   ok_s  [NS-1:3];

	// Dot products
	logic signed [TW-1:0]   t_s2 [NDOT][3];
	logic [2:0]             sm43_s2;
	logic [2:0]             sm21_s2;
	logic signed [DW-1:0]   d_s3 [NDOT];
	logic [PW-1:0]          m43_c [3];
	logic [PW-1:0]          m21_c [3];

	// Products of dot products
	logic [MW1-1:0]         m_s4 [NDOT];
	logic                   sg_s4 [NDOT];
	logic [2*DG-1:0]        pp_s5 [NPROD][ND1][ND1];
	logic                   psg_s5 [NPROD];
	logic [4*DG-1:0]        row_s6 [NPROD][ND1];
	logic                   psg_s6 [NPROD];
	logic [PMW-1:0]         pm_s7 [NPROD];
	logic                   psg_s7 [NPROD];
	logic signed [SW-1:0]   tm_s8 [NPROD];
	logic signed [SW-1:0]   dn_s9;
	logic signed [SW-1:0]   na_s9;
	logic signed [SW-1:0]   nb_s9;

	// Numerators times direction components
	logic [MW2-1:0]         dnm_s10, dnm_s11, dnm_s12, dnm_s13;
	logic                   dns_s10, dns_s11, dns_s12, dns_s13;
	logic [MW2-1:0]         nam_s10, nbm_s10;
	logic                   nas_s10, nbs_s10;
	logic [PW-1:0]          pm21_s10 [3];
	logic [PW-1:0]          pm43_s10 [3];
	logic                   ps21_s10 [3];
	logic                   ps43_s10 [3];
	logic [DG+PW-1:0]       pq_s11 [NLANE][ND2];
	logic                   lsg_s11 [NLANE];
	logic                   dok_c;
	logic [2*DG+PW-1:0]     ps_s12 [NLANE][NPAIR];
	logic                   lsg_s12 [NLANE];
	logic [NW-1:0]          nmg_s13 [NLANE];
	logic                   lsg_s13 [NLANE];
	logic signed [CW-1:0]   cres [NLANE];

	// Stage enables: a stage loads when it is empty or the next one loads.
	always_comb begin
		en[NS] = !vld_q[NS] || !res_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign req_stall = !en[1];
	assign res_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= req_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Configuration registers
	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[AW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_coord_q <= EPS_COORD_RST;
			eps_denom_q <= EPS_DENOM_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (ridx)
				REG_EPS_COORD: eps_coord_q <= pwdata[ECW-1:0];
				REG_EPS_DENOM: eps_denom_q <= pwdata[EDW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_EPS_COORD: prdata = PDW'(eps_coord_q);
			REG_EPS_DENOM: prdata = PDW'(eps_denom_q);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		as_c = '{a_start_x, a_start_y, a_start_z};
		ae_c = '{a_end_x, a_end_y, a_end_z};
		bs_c = '{b_start_x, b_start_y, b_start_z};
		be_c = '{b_end_x, b_end_y, b_end_z};
	end

	// Stage 1 forms the differences; the points and directions then travel along.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				p1_s[1][i]  <= as_c[i];
				p3_s[1][i]  <= bs_c[i];
				p13_s1[i]   <= PW'(as_c[i]) - PW'(bs_c[i]);
				p43_s[1][i] <= PW'(be_c[i]) - PW'(bs_c[i]);
				p21_s[1][i] <= PW'(ae_c[i]) - PW'(as_c[i]);
			end
		end
		for (int k = 2; k < ST_DIV; k++) begin
			if (en[k]) begin
				p1_s[k]  <= p1_s[k-1];
				p3_s[k]  <= p3_s[k-1];
				p43_s[k] <= p43_s[k-1];
				p21_s[k] <= p21_s[k-1];
			end
		end
	end

	// Stage 2: the fifteen products of the dot products and the small-component tests.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m43_c[i] = p43_s[1][i][PW-1] ? PW'(-p43_s[1][i]) : PW'(p43_s[1][i]);
			m21_c[i] = p21_s[1][i][PW-1] ? PW'(-p21_s[1][i]) : PW'(p21_s[1][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				t_s2[D1343][i] <= TW'(p13_s1[i]) * TW'(p43_s[1][i]);
				t_s2[D4321][i] <= TW'(p43_s[1][i]) * TW'(p21_s[1][i]);
				t_s2[D1321][i] <= TW'(p13_s1[i]) * TW'(p21_s[1][i]);
				t_s2[D4343][i] <= TW'(p43_s[1][i]) * TW'(p43_s[1][i]);
				t_s2[D2121][i] <= TW'(p21_s[1][i]) * TW'(p21_s[1][i]);
				sm43_s2[i] <= m43_c[i] < PW'(eps_coord_q);
				sm21_s2[i] <= m21_c[i] < PW'(eps_coord_q);
			end
		end
	end

	// Stage 3 sums the dot products; stage 4 splits them into sign and magnitude.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int d = 0; d < NDOT; d++) begin
				d_s3[d] <= DW'(t_s2[d][0]) + DW'(t_s2[d][1]) + DW'(t_s2[d][2]);
			end
		end
		if (en[4]) begin
			for (int d = 0; d < NDOT; d++) begin
				m_s4[d]  <= d_s3[d][DW-1] ? MW1'(DW'(-d_s3[d])) : MW1'(DW'(d_s3[d]));
				sg_s4[d] <= d_s3[d][DW-1];
			end
		end
	end

	// Stages 5 to 7 multiply dot products digit by digit and add up the partials.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int p = 0; p < NPROD; p++) begin
				for (int i = 0; i < ND1; i++) begin
					for (int j = 0; j < ND1; j++) begin
						pp_s5[p][i][j] <= m_s4[PA[p]][i*DG +: DG] * m_s4[PB[p]][j*DG +: DG];
					end
				end
				psg_s5[p] <= sg_s4[PA[p]] ^ sg_s4[PB[p]];
			end
		end
		if (en[6]) begin
			for (int p = 0; p < NPROD; p++) begin
				for (int i = 0; i < ND1; i++) begin
					row_s6[p][i] <= (4*DG)'(pp_s5[p][i][0])
						+ ((4*DG)'(pp_s5[p][i][1]) << DG)
						+ ((4*DG)'(pp_s5[p][i][2]) << (2*DG));
				end
				psg_s6[p] <= psg_s5[p];
			end
		end
		if (en[7]) begin
			for (int p = 0; p < NPROD; p++) begin
				pm_s7[p] <= PMW'(row_s6[p][0]) + (PMW'(row_s6[p][1]) << DG)
					+ (PMW'(row_s6[p][2]) << (2*DG));
				psg_s7[p] <= psg_s6[p];
			end
		end
	end

	// Stage 8 restores signs; stage 9 forms the denominator and both numerators.
	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int p = 0; p < NPROD; p++) begin
				tm_s8[p] <= psg_s7[p] ? -SW'(pm_s7[p]) : SW'(pm_s7[p]);
			end
		end
		if (en[9]) begin
			dn_s9 <= tm_s8[0] - tm_s8[1];
			na_s9 <= tm_s8[2] - tm_s8[3];
			nb_s9 <= tm_s8[4] - tm_s8[5];
		end
	end

	// Stage 10 takes magnitudes of the big values and of the direction components.
	always_ff @(posedge clk) begin
		if (en[10]) begin
			dnm_s10 <= dn_s9[SW-1] ? MW2'(-dn_s9) : MW2'(dn_s9);
			dns_s10 <= dn_s9[SW-1];
			nam_s10 <= na_s9[SW-1] ? MW2'(-na_s9) : MW2'(na_s9);
			nas_s10 <= na_s9[SW-1];
			nbm_s10 <= nb_s9[SW-1] ? MW2'(-nb_s9) : MW2'(nb_s9);
			nbs_s10 <= nb_s9[SW-1];
			for (int i = 0; i < 3; i++) begin
				pm21_s10[i] <= p21_s[9][i][PW-1] ? PW'(-p21_s[9][i]) : PW'(p21_s[9][i]);
				ps21_s10[i] <= p21_s[9][i][PW-1];
				pm43_s10[i] <= p43_s[9][i][PW-1] ? PW'(-p43_s[9][i]) : PW'(p43_s[9][i]);
				ps43_s10[i] <= p43_s[9][i][PW-1];
			end
		end
	end

	// The denominator must be nonzero and at least the threshold.
	assign dok_c = (dnm_s10 != '0) && (dnm_s10 >= (MW2'(eps_denom_q) << EPS_SH));

	// Stages 11 to 13: numerator times direction component, one lane per output.
	always_ff @(posedge clk) begin
		if (en[11]) begin
			for (int l = 0; l < NLANE; l++) begin
				for (int d = 0; d < ND2; d++) begin
					pq_s11[l][d] <= (l < 3)
						? (nam_s10[d*DG +: DG] * pm21_s10[l % 3])
						: (nbm_s10[d*DG +: DG] * pm43_s10[l % 3]);
				end
				lsg_s11[l] <= (l < 3) ? (nas_s10 ^ ps21_s10[l % 3])
					: (nbs_s10 ^ ps43_s10[l % 3]);
			end
			dnm_s11 <= dnm_s10;
			dns_s11 <= dns_s10;
		end
		if (en[12]) begin
			for (int l = 0; l < NLANE; l++) begin
				for (int m = 0; m < NPAIR; m++) begin
					ps_s12[l][m] <= (2*DG+PW)'(pq_s11[l][2*m])
						+ ((2*DG+PW)'(pq_s11[l][2*m+1]) << DG);
				end
				lsg_s12[l] <= lsg_s11[l];
			end
			dnm_s12 <= dnm_s11;
			dns_s12 <= dns_s11;
		end
		if (en[13]) begin
			for (int l = 0; l < NLANE; l++) begin
				nmg_s13[l] <= NW'(ps_s12[l][0]) + (NW'(ps_s12[l][1]) << (2*DG))
					+ (NW'(ps_s12[l][2]) << (4*DG));
				lsg_s13[l] <= lsg_s12[l];
			end
			dnm_s13 <= dnm_s12;
			dns_s13 <= dns_s12;
		end
	end

	// Result flag: degenerate lines drop it at stage 3, a small denominator at 11.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			ok_s[3] <= !((&sm43_s2) || (&sm21_s2));
		end
		for (int k = 4; k < NS; k++) begin
			if (en[k]) begin
				if (k == 11) begin
					ok_s[11] <= ok_s[10] && dok_c;
				end else begin
					ok_s[k] <= ok_s[k-1];
				end
			end
		end
	end

	// Divider lanes: three for line A, three for line B.
	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		lcp_div u_div (
			.clk  (clk),
			.en   (en[NS-1:ST_DIV]),
			.sgn  ({lsg_s13[l], dns_s13}),
			.nm   (nmg_s13[l]),
			.dm   (dnm_s13),
			.base ((l < 3) ? p1_s[ST_DIV-1][l % 3] : p3_s[ST_DIV-1][l % 3]),
			.res  (cres[l])
		);
	end

	// Output register; an invalid result carries zero points.
	always_ff @(posedge clk) begin
		if (en[NS]) begin
			found       <= ok_s[NS-1];
			closest_a_x <= ok_s[NS-1] ? cres[0] : '0;
			closest_a_y <= ok_s[NS-1] ? cres[1] : '0;
			closest_a_z <= ok_s[NS-1] ? cres[2] : '0;
			closest_b_x <= ok_s[NS-1] ? cres[3] : '0;
			closest_b_y <= ok_s[NS-1] ? cres[4] : '0;
			closest_b_z <= ok_s[NS-1] ? cres[5] : '0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/lcp_chk.sv @@
// Port-level checks for the 3D line closest-points pipeline, bound to its top level.
// Depends on lcp_pkg.
`default_nettype none

module lcp_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_stall,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  logic                           found,
	input  logic signed [lcp_pkg::CW-1:0]  closest_a_x,
	input  logic signed [lcp_pkg::CW-1:0]  closest_a_y,
	input  logic signed [lcp_pkg::CW-1:0]  closest_a_z,
	input  logic signed [lcp_pkg::CW-1:0]  closest_b_x,
	input  logic signed [lcp_pkg::CW-1:0]  closest_b_y,
	input  logic signed [lcp_pkg::CW-1:0]  closest_b_z
);

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps found, closest_a_x and closest_b_z unchanged.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(found) && $stable(closest_a_x)
			&& $stable(closest_b_z))
		else $error("result payload changed while stalled");

	// An empty output register lets every stage move, so no request is held off.
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !req_stall)
		else $error("request stalled with an empty output");

	// A result without closest points carries zero points.
	a_zero_points: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> closest_a_x == 0 && closest_a_y == 0
			&& closest_a_z == 0 && closest_b_x == 0 && closest_b_y == 0
			&& closest_b_z == 0)
		else $error("invalid result with nonzero points");

endmodule

bind line_closest_points_3d lcp_chk u_lcp_chk (.*);

`default_nettype wire
